/* hw/rtl/kxse_pkg.sv */
// Package for the keyed XOR section encryptor.
// Holds item structs and keystream constants; no dependencies.
`default_nettype none

package kxse_pkg;

    localparam int KEY_W = 16;
    localparam int KS_W  = 24;
    localparam int CS_W  = 32;
    localparam int PH_W  = 4;

    localparam logic [PH_W-1:0] PHASE_LAST = 4'hF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_section;
    } t_in_item;

    typedef struct packed {
        logic [7:0]      cipher_byte;
        logic [CS_W-1:0] running_checksum;
        logic            section_done;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/kxse_core.sv */
// Keystream, phase and checksum state with the per-item step.
// Depends on kxse_pkg.
`default_nettype none

module kxse_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [15:0]       i_key,
    input  kxse_pkg::t_in_item     i_item,
    output kxse_pkg::t_out_item    o_result
);
    import kxse_pkg::*;

    logic [KS_W-1:0] r_ks;
    logic [KS_W-1:0] n_ks;
    logic [PH_W-1:0] r_phase;
    logic [PH_W-1:0] n_phase;
    logic [CS_W-1:0] r_cs;
    logic [CS_W-1:0] n_cs;
    logic            r_start;

    logic [KS_W-1:0] ks_cur;
    logic [PH_W-1:0] phase_cur;
    logic [CS_W-1:0] cs_cur;

    always_comb begin
        ks_cur    = r_start ? {i_key[7:0], i_key} : r_ks;
        phase_cur = r_start ? '0 : r_phase;
        cs_cur    = r_start ? '0 : r_cs;

        n_cs    = {cs_cur[CS_W-2:0], 1'b0} + {{(CS_W-8){1'b0}}, i_item.data_byte};
        n_ks    = {ks_cur[KS_W-2:0], 1'b0};
        if (phase_cur == PHASE_LAST) begin
            n_ks = n_ks | {{(KS_W-KEY_W){1'b0}}, i_key};
        end
        n_phase = phase_cur + 1'b1;

        o_result.cipher_byte      = i_item.data_byte ^ ks_cur[KS_W-1:KS_W-8];
        o_result.running_checksum = n_cs;
        o_result.section_done     = i_item.end_of_section;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks    <= '0;
            r_phase <= '0;
            r_cs    <= '0;
            r_start <= 1'b1;
        end else if (i_step) begin
            r_ks    <= n_ks;
            r_phase <= n_phase;
            r_cs    <= n_cs;
            r_start <= i_item.end_of_section;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/keyed_xor_section_encryptor_unit.sv */
// Top level of the keyed XOR section encryptor: handshake, key and result registers.
// Depends on kxse_pkg and kxse_core.
//
// Use:
//   Input channel i_valid / o_stall / i_item carries one plaintext byte per item,
//   with end_of_section set on the last byte of a section. Output channel
//   o_valid / i_stall / o_item returns one result per item: cipher byte, running
//   checksum and the section-done flag. The key is written through
//   i_cfg_wr_en / i_cfg_wr_data; the user must do so only while no item is in
//   flight, which the block does not enforce. An accepted item goes into the input
//   register, then through the keystream step into the result register, which
//   drives o_item. Throughput: one item per cycle while the receiver does not stall.
//   Reset (synchronous, active low) empties both registers, clears the key
//   and arms a new section.
//   When the receiver stalls, the result holds; the input register takes one
//   more item, then o_stall rises until the result is taken.
`default_nettype none

module keyed_xor_section_encryptor_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  kxse_pkg::t_in_item     i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output kxse_pkg::t_out_item    o_item,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [15:0]       i_cfg_wr_data
);
    import kxse_pkg::*;

    logic [KEY_W-1:0] r_key;
    t_in_item         r_in;
    logic             r_in_valid;
    t_out_item        r_out;
    logic             r_out_valid;
    t_out_item        step_result;
    logic             advance;
    logic             accept;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    kxse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_key    (r_key),
        .i_item   (r_in),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_key <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kxse_checker.sv */
// Port-level checks for keyed_xor_section_encryptor_unit, bound to the top level.
// Depends on kxse_pkg.
`default_nettype none

module kxse_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input kxse_pkg::t_in_item     i_item,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input kxse_pkg::t_out_item    o_item
);
    import kxse_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("stalled input item changed");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 o_valid)
        else $error("accepted item produced no result");

endmodule

bind keyed_xor_section_encryptor_unit kxse_checker u_kxse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

`default_nettype wire

/* tb/sv/keyed_xor_section_encryptor_unit_test.sv */
// Self-checking testbench for keyed_xor_section_encryptor_unit: directed table, then random
// sections under several keys, with random valid gaps and result stalls.
// Depends on kxse_pkg and the encryptor RTL only.
`timescale 1ns / 1ps

module keyed_xor_section_encryptor_unit_test;

    import kxse_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int PHASE_ITEMS    = 75;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        bit        wr_key;
        bit [15:0] key;
        bit [7:0]  data;
        bit        eos;
        bit        pinned;
        bit [7:0]  cipher;
        bit [31:0] csum;
    } t_step_row;

    // pinned rows carry a fixed expected cipher byte and checksum in place of the model's
    localparam t_step_row STEPS [25] = '{
        '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00, 32'h0000_0000},
        '{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b1, 8'hFF, 32'h0000_00FF},
        '{1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'h00, 32'h0000_00FF},
        '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 8'hFF, 32'h0000_0000},
        '{1'b1, 16'hA55A, 8'h3C, 1'b0, 1'b1, 8'h66, 32'h0000_003C},
        '{1'b0, 16'h0000, 8'h81, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h7E, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h01, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h80, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'hC3, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b1, 16'h00FF, 8'h55, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'hAA, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h10, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h20, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h40, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'hFE, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h7F, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h08, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'hE7, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h5A, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h99, 1'b0, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'h3C, 1'b1, 1'b0, 8'h00, 32'h0},
        '{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b1, 8'h00, 32'h0000_00FF},
        '{1'b1, 16'h8001, 8'h00, 1'b0, 1'b1, 8'h01, 32'h0000_0000},
        '{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b0, 8'h00, 32'h0}
    };

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_valid       = 1'b0;
    logic            o_stall;
    t_in_item        i_item        = '0;
    logic            o_valid;
    logic            i_stall       = 1'b0;
    t_out_item       o_item;
    logic            i_cfg_wr_en   = 1'b0;
    logic [15:0]     i_cfg_wr_data = '0;

    logic            pin_en     = 1'b0;
    logic [7:0]      pin_cipher = '0;
    logic [CS_W-1:0] pin_csum   = '0;
    logic            calm       = 1'b0;

    // encryptor state as predicted
    logic [KEY_W-1:0] key_model   = '0;
    logic [KS_W-1:0]  ks_model    = '0;
    logic [PH_W-1:0]  phase_model = '0;
    logic [CS_W-1:0]  sum_model   = '0;
    logic             new_section = 1'b1;

    t_out_item expected_results [$];
    int        mismatches   = 0;
    int        idle_cycles  = 0;
    int        stall_left   = 0;
    int        section_left = 0;

    keyed_xor_section_encryptor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item        (o_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_item encrypt_byte(input t_in_item it);
        t_out_item r;
        if (new_section) begin
            ks_model    = {key_model[7:0], key_model};
            phase_model = '0;
            sum_model   = '0;
            new_section = 1'b0;
        end
        sum_model          = (sum_model << 1) + CS_W'(it.data_byte);
        r.cipher_byte      = it.data_byte ^ ks_model[23:16];
        r.running_checksum = sum_model;
        r.section_done     = it.end_of_section;
        ks_model = ks_model << 1;
        if (phase_model == PHASE_LAST) begin
            ks_model[15:0] = ks_model[15:0] | key_model;
        end
        phase_model = phase_model + 1'b1;
        if (it.end_of_section) begin
            new_section = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_cfg_wr_en) begin
            key_model = i_cfg_wr_data;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            want = encrypt_byte(i_item);
            if (pin_en) begin
                want.cipher_byte      = pin_cipher;
                want.running_checksum = pin_csum;
            end
            expected_results.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: %p", o_item);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_item.cipher_byte !== want.cipher_byte) begin
                    $error("cipher_byte: expected %02h, got %02h",
                           want.cipher_byte, o_item.cipher_byte);
                    mismatches++;
                end
                if (o_item.running_checksum !== want.running_checksum) begin
                    $error("running_checksum: expected %08h, got %08h",
                           want.running_checksum, o_item.running_checksum);
                    mismatches++;
                end
                if (o_item.section_done !== want.section_done) begin
                    $error("section_done: expected %0b, got %0b",
                           want.section_done, o_item.section_done);
                    mismatches++;
                end
            end
        end
    end

    // result stalls in bursts of random length, none once calm is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!i_stall && !calm && $urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic eos, input bit pin,
                             input logic [7:0] cipher, input logic [CS_W-1:0] csum);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_item.data_byte    <= data;
        i_item.end_of_section <= eos;
        pin_en              <= pin;
        pin_cipher          <= cipher;
        pin_csum            <= csum;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [15:0] k);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= k;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // sections carry over phase boundaries, so keys also change mid-section
    task automatic run_phase(input logic [15:0] k, input int count);
        logic [7:0] data;
        load_key(k);
        repeat (count) begin
            if (section_left == 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:  section_left = $urandom_range(21, 48);
                    3, 4:     section_left = 1;
                    default:  section_left = $urandom_range(2, 20);
                endcase
            end
            data = 8'($urandom_range(0, 255));
            push_byte(data, section_left == 1, 1'b0, '0, '0);
            section_left--;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (STEPS[n]) begin
            if (STEPS[n].wr_key) begin
                load_key(STEPS[n].key);
            end
            push_byte(STEPS[n].data, STEPS[n].eos, STEPS[n].pinned,
                      STEPS[n].cipher, STEPS[n].csum);
        end

        run_phase(16'h0000, PHASE_ITEMS);
        run_phase(16'hFFFF, PHASE_ITEMS);
        run_phase(16'($urandom()), PHASE_ITEMS);
        run_phase(16'h8001, PHASE_ITEMS);
        run_phase(16'($urandom()), PHASE_ITEMS);
        calm <= 1'b1;
        run_phase(16'($urandom()), PHASE_ITEMS);

        drain();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result items never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
